// ----- sv/tcw_pkg.sv -----
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Internal widths that follow from the geometry.
  localparam int CUR_W  = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  // Field widths of the stream items.
  localparam int CHAR_W     = 8;
  localparam int CELL_W     = 2 * CHAR_W;
  localparam int POS_W      = 11;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // Control characters and the forced foreground bits of a blank cell.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] RETURN_CODE  = 8'd13;
  localparam logic [CHAR_W-1:0] FORE_BITS    = 8'h0F;

  // A blank cell holds NUL with the given background and a white foreground.
  function automatic logic [CELL_W-1:0] blank_cell(input logic [CHAR_W-1:0] bg);
    blank_cell = {bg | FORE_BITS, {CHAR_W{1'b0}}};
  endfunction

endpackage

// ----- sv/text_console_cell_writer.sv -----
// Text console cell writer. The screen (tcw_pkg::ROWS x tcw_pkg::COLUMNS cells of
// character plus attribute) lives in one single-port-write, registered-read
// memory. Each item on the slave stream gives exactly one item on the master
// stream. A put, newline or carriage return finishes in the accepting cycle; a
// read cell finishes in ST_READ, once the registered memory read returns; for a
// set cursor the row of the position comes from a multiply by the reciprocal of
// COLUMNS in the accepting cycle, and the row start and column follow in
// ST_DIVIDE. A clear screen is the accepting cycle, then a walk that writes one
// cell a cycle. A put or newline that passes the last cell scrolls: after the
// accepting cycle, a copy walk reads each cell one row below and writes it back
// once the registered read returns, then a walk fills the bottom row. Out-of-range
// positions for set cursor and read cell finish in the accepting cycle with
// bad_position set. A finished item waits in a skid register, so one new item
// is taken while the output is stalled.
module text_console_cell_writer (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: clear_background for the row freed by a scroll.
  input  logic                            cfg_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0]      cfg_wr_data,
  // Input items.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // character [7:0], attribute [15:8], position [26:16], zero [31:27]
  input  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind [1:0]
  input  logic [tcw_pkg::KIND_W-1:0]      s_axis_tuser,
  // Result items.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_character [7:0], read_attribute [15:8], cursor_position [26:16],
  // scrolled [27], bad_position [28], zero [31:29]
  output logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_DIVIDE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] rd_chr;
    logic [CHAR_W-1:0] rd_attr;
    logic [POS_W-1:0]  cursor;
    logic              scrolled;
    logic              bad;
  } result_t;

  localparam logic [CUR_W-1:0] COPY_LAST = CUR_W'(CELLS - COLUMNS);
  localparam logic [CUR_W-1:0] CELL_LAST = CUR_W'(CELLS - 1);
  localparam logic [CUR_W-1:0] COLS_C    = CUR_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

  // Reciprocal of COLUMNS, exact for every position below 2**CUR_W.
  localparam int               DIV_SHIFT = CUR_W + COL_W;
  localparam logic [CUR_W+1:0] RECIP     =
    (CUR_W+2)'((2 ** DIV_SHIFT + COLUMNS - 1) / COLUMNS);

  // Screen memory.
  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [CUR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CUR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0] rd_data;

  // Control and cursor state.
  state_t            state;
  logic [CUR_W-1:0]  cursor;
  logic [CUR_W-1:0]  line_start;
  logic [COL_W-1:0]  col;
  logic [CUR_W-1:0]  ptr;
  logic [CELL_W-1:0] fill_cell;
  logic              is_scroll;
  logic [ROW_W-1:0]  pos_row;
  logic [CHAR_W-1:0] clear_background;

  // Output and skid registers.
  logic              out_valid;
  result_t           out_res;
  logic              pend;
  result_t           pend_res;

  // Unpacked input fields.
  logic [CHAR_W-1:0] in_chr;
  logic [CHAR_W-1:0] in_attr;
  logic [POS_W-1:0]  in_pos;
  logic              accept;
  logic              pos_ok;
  logic              is_ctrl;

  // Put arithmetic.
  logic [CUR_W:0]    ls_next;
  logic [CUR_W:0]    cursor_next;
  logic [COL_W-1:0]  col_next;
  logic              wrap;

  // Row of a set-cursor position.
  logic [2*CUR_W+1:0] pos_prod;
  logic [CUR_W-1:0]   pos_line;

  // Result of the item that finishes this cycle.
  logic              fin_valid;
  result_t           fin_res;

  assign in_chr  = s_axis_tdata[CHAR_W-1:0];
  assign in_attr = s_axis_tdata[CELL_W-1:CHAR_W];
  assign in_pos  = s_axis_tdata[CELL_W+POS_W-1:CELL_W];

  assign s_axis_tready = (state == ST_IDLE) && !pend;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos_ok        = (16'(in_pos) < 16'(CELLS));
  assign is_ctrl       = (in_chr == NEWLINE_CODE) || (in_chr == RETURN_CODE);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_res.bad, out_res.scrolled, out_res.cursor,
                                      out_res.rd_attr, out_res.rd_chr});

  // Cursor movement for a put, newline or carriage return.
  always_comb begin
    ls_next     = {1'b0, line_start};
    col_next    = '0;
    cursor_next = {1'b0, line_start};
    if (in_chr == NEWLINE_CODE) begin
      ls_next     = {1'b0, line_start} + (CUR_W+1)'(COLUMNS);
      cursor_next = ls_next;
    end else if (in_chr == RETURN_CODE) begin
      cursor_next = {1'b0, line_start};
    end else if (col == COL_LAST) begin
      ls_next     = {1'b0, line_start} + (CUR_W+1)'(COLUMNS);
      cursor_next = ls_next;
    end else begin
      col_next    = col + COL_W'(1);
      cursor_next = {1'b0, cursor} + (CUR_W+1)'(1);
    end
  end

  assign wrap = (cursor_next == (CUR_W+1)'(CELLS));

  // Row of the position by reciprocal multiplication, then its first cell.
  assign pos_prod = {{(CUR_W+2){1'b0}}, CUR_W'(in_pos)} * {{CUR_W{1'b0}}, RECIP};
  assign pos_line = CUR_W'(pos_row) * COLS_C;

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor;
    mem_wdata = {in_attr, in_chr};
    mem_raddr = CUR_W'(in_pos);
    case (state)
      ST_IDLE: begin
        mem_we = accept && (s_axis_tuser == KIND_PUT) && !is_ctrl;
      end
      ST_SCROLL: begin
        // Reads run ahead of writes through the registered read port, and each cell
        // written is copied from one row further down, so a cell is always read before it is overwritten.
        mem_raddr = (ptr < COPY_LAST) ? (ptr + COLS_C) : ptr;
        mem_we    = (ptr != '0);
        mem_waddr = ptr - CUR_W'(1);
        mem_wdata = rd_data;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = fill_cell;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Result of the item that completes in this cycle.
  always_comb begin
    fin_valid       = 1'b0;
    fin_res         = '0;
    fin_res.cursor  = POS_W'(cursor);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            KIND_PUT: begin
              fin_valid      = !wrap;
              fin_res.cursor = POS_W'(cursor_next[CUR_W-1:0]);
            end
            KIND_SET, KIND_READ: begin
              fin_valid   = !pos_ok;
              fin_res.bad = 1'b1;
            end
            default: begin
              fin_valid = 1'b0;
            end
          endcase
        end
      end
      ST_FILL: begin
        fin_valid        = (ptr == CELL_LAST);
        fin_res.scrolled = is_scroll;
      end
      ST_DIVIDE: begin
        fin_valid = 1'b1;
      end
      ST_READ: begin
        fin_valid       = 1'b1;
        fin_res.rd_chr  = rd_data[CHAR_W-1:0];
        fin_res.rd_attr = rd_data[CELL_W-1:CHAR_W];
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  // State machine, cursor registers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cursor           <= '0;
      line_start       <= '0;
      col              <= '0;
      ptr              <= '0;
      is_scroll        <= 1'b0;
      clear_background <= '0;
      out_valid        <= 1'b0;
      pend             <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clear_background <= cfg_wr_data;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_axis_tuser)
              KIND_PUT: begin
                if (wrap) begin
                  line_start <= COPY_LAST;
                  col        <= '0;
                  cursor     <= COPY_LAST;
                  ptr        <= '0;
                  is_scroll  <= 1'b1;
                  state      <= ST_SCROLL;
                end else begin
                  line_start <= ls_next[CUR_W-1:0];
                  col        <= col_next;
                  cursor     <= cursor_next[CUR_W-1:0];
                end
              end
              KIND_CLEAR: begin
                ptr       <= '0;
                fill_cell <= blank_cell(in_attr);
                is_scroll <= 1'b0;
                state     <= ST_FILL;
              end
              KIND_SET: begin
                if (pos_ok) begin
                  cursor  <= CUR_W'(in_pos);
                  pos_row <= pos_prod[DIV_SHIFT+ROW_W-1:DIV_SHIFT];
                  state   <= ST_DIVIDE;
                end
              end
              default: begin
                if (pos_ok) begin
                  state <= ST_READ;
                end
              end
            endcase
          end
        end
        ST_SCROLL: begin
          if (ptr == COPY_LAST) begin
            // Copy done; ptr now points at the bottom row.
            fill_cell <= blank_cell(clear_background);
            state     <= ST_FILL;
          end else begin
            ptr <= ptr + CUR_W'(1);
          end
        end
        ST_FILL: begin
          if (ptr == CELL_LAST) begin
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + CUR_W'(1);
          end
        end
        ST_DIVIDE: begin
          // Row start and column of the new cursor.
          line_start <= pos_line;
          col        <= COL_W'(cursor - pos_line);
          state      <= ST_IDLE;
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Output register with a one-item skid behind it.
      if (!out_valid || m_axis_tready) begin
        if (pend) begin
          out_res   <= pend_res;
          out_valid <= 1'b1;
          pend      <= 1'b0;
        end else if (fin_valid) begin
          out_res   <= fin_res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (fin_valid) begin
        pend_res <= fin_res;
        pend     <= 1'b1;
      end
    end
  end

endmodule

// ----- tb/tcw_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams and the configuration port of the console writer.
// Every accepted command is run through a shadow copy of the screen, and the
// result it should give is queued. Every accepted result is checked against
// the oldest queued one.
module tcw_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0]     cfg_wr_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [tcw_pkg::KIND_W-1:0]     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                             fail_count,
  output int                             results_pending
);

  localparam int CELLS   = tcw_pkg::CELLS;
  localparam int COLUMNS = tcw_pkg::COLUMNS;
  localparam int CUR_W   = tcw_pkg::CUR_W;

  // Result item, laid out as on the master stream; members run from the top bit down.
  typedef struct packed {
    logic                        bad_position;
    logic                        scrolled;
    logic [tcw_pkg::POS_W-1:0]   cursor_position;
    logic [tcw_pkg::CHAR_W-1:0]  read_attribute;
    logic [tcw_pkg::CHAR_W-1:0]  read_character;
  } console_result_t;

  // Shadow of the screen: attribute in the high byte, character in the low.
  logic [tcw_pkg::CELL_W-1:0] screen_shadow [CELLS];
  int                         cursor_shadow;
  logic [tcw_pkg::CHAR_W-1:0] background_shadow;

  console_result_t expected_results[$];
  int              mismatches;

  // Applies one command to the shadow screen and returns the result it gives.
  function automatic console_result_t apply_command(
    input logic [tcw_pkg::KIND_W-1:0] kind_in,
    input logic [tcw_pkg::CHAR_W-1:0] chr,
    input logic [tcw_pkg::CHAR_W-1:0] attr,
    input logic [tcw_pkg::POS_W-1:0]  pos
  );
    console_result_t res;
    res = '0;
    case (kind_in)
      tcw_pkg::KIND_PUT: begin
        if (chr == tcw_pkg::NEWLINE_CODE) begin
          cursor_shadow = cursor_shadow + COLUMNS - (cursor_shadow % COLUMNS);
        end else if (chr == tcw_pkg::RETURN_CODE) begin
          cursor_shadow = cursor_shadow - (cursor_shadow % COLUMNS);
        end else begin
          screen_shadow[CUR_W'(cursor_shadow)] = {attr, chr};
          cursor_shadow++;
        end
        // Past the last cell: move every row up and blank the bottom one.
        if (cursor_shadow >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_shadow[CUR_W'(i)] = screen_shadow[CUR_W'(i + COLUMNS)];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_shadow[CUR_W'(i)] = {background_shadow | tcw_pkg::FORE_BITS, 8'h00};
          end
          cursor_shadow = cursor_shadow - COLUMNS;
          res.scrolled = 1'b1;
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_shadow[CUR_W'(i)] = {attr | tcw_pkg::FORE_BITS, 8'h00};
        end
      end
      tcw_pkg::KIND_SET: begin
        if (int'(pos) < CELLS) begin
          cursor_shadow = int'(pos);
        end else begin
          res.bad_position = 1'b1;
        end
      end
      default: begin
        if (int'(pos) < CELLS) begin
          res.read_character = screen_shadow[pos][7:0];
          res.read_attribute = screen_shadow[pos][15:8];
        end else begin
          res.bad_position = 1'b1;
        end
      end
    endcase
    res.cursor_position = tcw_pkg::POS_W'(cursor_shadow);
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Compare results first, then queue the prediction for a new command.
  always @(posedge clk) begin : watch
    console_result_t want;
    console_result_t got;
    if (rst) begin
      expected_results.delete();
      cursor_shadow = 0;
      background_shadow = '0;
      mismatches = 0;
      for (int i = 0; i < CELLS; i++) begin
        screen_shadow[CUR_W'(i)] = '0;
      end
    end else begin
      if (cfg_wr_en) begin
        background_shadow = cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(console_result_t)-1:0];
        if (expected_results.size() == 0) begin
          $error("result item with no command outstanding: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_character", 32'(want.read_character),
                      32'(got.read_character));
          check_field("read_attribute", 32'(want.read_attribute),
                      32'(got.read_attribute));
          check_field("cursor_position", 32'(want.cursor_position),
                      32'(got.cursor_position));
          check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
          check_field("bad_position", 32'(want.bad_position), 32'(got.bad_position));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_command(s_axis_tuser, s_axis_tdata[7:0],
                                                 s_axis_tdata[15:8], s_axis_tdata[26:16]));
      end
    end
    fail_count <= mismatches;
    results_pending <= expected_results.size();
  end

endmodule

// ----- tb/tb_text_console_cell_writer.sv -----
`timescale 1ns / 1ps

module tb_text_console_cell_writer;

  localparam int CELLS          = tcw_pkg::CELLS;
  localparam int COLUMNS        = tcw_pkg::COLUMNS;
  localparam int MAX_POSITION   = 2047;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Positions used by the directed part.
  localparam logic [tcw_pkg::POS_W-1:0] POS_PAST_END  = tcw_pkg::POS_W'(CELLS);
  localparam logic [tcw_pkg::POS_W-1:0] POS_LAST_CELL = tcw_pkg::POS_W'(CELLS - 1);
  localparam logic [tcw_pkg::POS_W-1:0] POS_ROW_ABOVE = tcw_pkg::POS_W'(CELLS - COLUMNS - 1);

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [tcw_pkg::CHAR_W-1:0]      cfg_wr_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [tcw_pkg::KIND_W-1:0]      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

  int fail_count;
  int results_pending;

  // Sender pacing, receiver hold request and the watchdog count.
  bit gaps_on = 1'b1;
  int burst_left = 0;
  logic hold_req = 1'b0;
  int idle_cycles = 0;

  // Receiver state, owned by the receiver process alone.
  bit hold_done;
  int hold_left;
  int rx_mode;
  int rx_mode_left;
  int rx_tick;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_cell_writer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tcw_result_checker result_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // Receiver: one long hold when asked, otherwise a stall pattern that changes
  // its mode whenever a randomly drawn mode length runs out, including stretches that never stall.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      rx_mode = 0;
      rx_mode_left = 0;
      rx_tick = 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(32, 400);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  // Watchdog: ends the run when nothing moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one command and returns at the edge where it is accepted. In burst
  // mode a random gap is inserted whenever the current burst runs out.
  task automatic send_command(input logic [tcw_pkg::KIND_W-1:0] cmd_kind,
                              input logic [tcw_pkg::CHAR_W-1:0] chr,
                              input logic [tcw_pkg::CHAR_W-1:0] attr,
                              input logic [tcw_pkg::POS_W-1:0]  pos);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_axis_tdata <= {5'b0, pos, attr, chr};
    s_axis_tuser <= cmd_kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_background(input logic [tcw_pkg::CHAR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Positions lean toward the bottom row so that scrolls happen often.
  function automatic logic [tcw_pkg::POS_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return tcw_pkg::POS_W'($urandom_range(CELLS - COLUMNS - 8, CELLS - 1));
    end else if (roll < 8) begin
      return tcw_pkg::POS_W'($urandom_range(0, CELLS - 1));
    end
    return tcw_pkg::POS_W'($urandom_range(CELLS, MAX_POSITION));
  endfunction

  // Random command mix: mostly text and cursor moves, reads, a rare clear.
  task automatic send_random_command();
    int pick;
    logic [tcw_pkg::KIND_W-1:0] cmd_kind;
    logic [tcw_pkg::CHAR_W-1:0] chr;
    logic [tcw_pkg::CHAR_W-1:0] attr;
    logic [tcw_pkg::POS_W-1:0]  pos;
    pick = $urandom_range(0, 99);
    cmd_kind = tcw_pkg::KIND_PUT;
    chr = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    attr = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    pos = tcw_pkg::POS_W'($urandom_range(0, MAX_POSITION));
    if (pick >= 40 && pick < 50) begin
      chr = tcw_pkg::NEWLINE_CODE;
    end else if (pick >= 50 && pick < 55) begin
      chr = tcw_pkg::RETURN_CODE;
    end else if (pick >= 55 && pick < 70) begin
      cmd_kind = tcw_pkg::KIND_SET;
      pos = pick_position();
    end else if (pick >= 70 && pick < 98) begin
      cmd_kind = tcw_pkg::KIND_READ;
      pos = pick_position();
    end else if (pick >= 98) begin
      cmd_kind = tcw_pkg::KIND_CLEAR;
    end
    send_command(cmd_kind, chr, attr, pos);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_background(8'h00);

    // Directed part. Before the first clear only cells already written are read.
    send_command(tcw_pkg::KIND_PUT, 8'h41, 8'h00, 11'd2047);
    send_command(tcw_pkg::KIND_PUT, 8'hFF, 8'hFF, 11'd0);
    send_command(tcw_pkg::KIND_PUT, 8'h00, 8'h1E, 11'd5);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0);
    send_command(tcw_pkg::KIND_READ, 8'hFF, 8'hFF, 11'd1);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2);
    // Positions off the screen are refused and flagged.
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2047);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, POS_PAST_END);
    send_command(tcw_pkg::KIND_SET, 8'h00, 8'h00, POS_PAST_END);
    send_command(tcw_pkg::KIND_SET, 8'hFF, 8'hFF, 11'd2047);
    // Carriage return and newline ignore the attribute.
    send_command(tcw_pkg::KIND_PUT, tcw_pkg::RETURN_CODE, 8'hFF, 11'd0);
    send_command(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, 8'h00, 11'd2047);
    // Clears with both extremes of the background.
    send_command(tcw_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 11'd2047);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, POS_LAST_CELL);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0);
    send_command(tcw_pkg::KIND_CLEAR, 8'h00, 8'h00, 11'd0);
    // A put in the last cell scrolls, and so does a newline on the bottom row.
    send_command(tcw_pkg::KIND_SET, 8'h00, 8'h00, POS_LAST_CELL);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, POS_LAST_CELL);
    send_command(tcw_pkg::KIND_PUT, 8'h5A, 8'h70, 11'd0);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, POS_ROW_ABOVE);
    send_command(tcw_pkg::KIND_READ, 8'h00, 8'h00, POS_LAST_CELL);
    send_command(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, 8'hFF, 11'd0);
    // A carriage return on the bottom row does not scroll.
    send_command(tcw_pkg::KIND_SET, 8'h00, 8'h00, POS_LAST_CELL);
    send_command(tcw_pkg::KIND_PUT, tcw_pkg::RETURN_CODE, 8'h00, 11'd0);
    send_command(tcw_pkg::KIND_SET, 8'h00, 8'h00, 11'd0);
    wait_drained();

    // Random traffic with a bursty sender, full background.
    write_background(8'hFF);
    repeat (180) send_random_command();
    wait_drained();

    // Long receiver hold while the sender keeps offering plain puts.
    write_background(tcw_pkg::CHAR_W'($urandom_range(0, 255)));
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    repeat (40) begin
      send_command(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                   tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                   tcw_pkg::POS_W'($urandom_range(0, MAX_POSITION)));
    end
    gaps_on = 1'b1;
    repeat (100) send_random_command();
    wait_drained();

    // Back-to-back traffic with a cleared background.
    write_background(8'h00);
    gaps_on = 1'b0;
    repeat (180) send_random_command();
    wait_drained();

    repeat (100) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- text_console_cell_writer.f -----
sv/tcw_pkg.sv
sv/text_console_cell_writer.sv
tb/tcw_result_checker.sv
tb/tb_text_console_cell_writer.sv
